FILE: sv/indexed_linked_list_manager_top_macros.svh
// Assertion macros shared by the linked list manager RTL.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef INDEXED_LINKED_LIST_MANAGER_TOP_MACROS_SVH
`define INDEXED_LINKED_LIST_MANAGER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ILLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ILLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/illm_pkg.sv
// Shared types and codes of the linked list manager.
// Used by illm_seq and the top level; no dependencies.
package illm_pkg;

    localparam logic [1:0] FUNC_APPEND = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;
    localparam logic [1:0] FUNC_READ   = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOENTRY = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    localparam logic [1:0] OPK_APPEND = 2'd0;
    localparam logic [1:0] OPK_HEAD   = 2'd1;
    localparam logic [1:0] OPK_AFTER  = 2'd2;

    localparam logic MOD_PREV = 1'b0;
    localparam logic MOD_NEXT = 1'b1;

    typedef struct packed {
        logic [1:0]  func;
        logic        at_head;
        logic [7:0]  position;
        logic [15:0] payload;
    } illm_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  entry_id;
        logic        entry_prev_valid;
        logic [7:0]  entry_prev;
        logic        entry_next_valid;
        logic [7:0]  entry_next;
        logic [15:0] entry_payload;
        logic        entry_deleted;
        logic        head_valid;
        logic [7:0]  head;
        logic        tail_valid;
        logic [7:0]  tail;
    } illm_res_t;

endpackage

FILE: sv/illm_ram.sv
// Entry table: one write port, one registered read port, write-first forwarding.
// No dependencies.
module illm_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 35
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/illm_seq.sv
// Sequencer of the linked list manager: decodes a request, walks and relinks
// entries by read-modify-write on the entry table. Depends on illm_pkg and the macros.
`include "indexed_linked_list_manager_top_macros.svh"

module illm_seq
    import illm_pkg::*;
#(
    parameter int ENTRIES      = 256,
    parameter int PAYLOAD_BITS = 16,
    parameter int IDX_W        = 8,
    parameter int WW           = 35
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  illm_req_t        req,
    output logic             res_valid,
    input  logic             res_ready,
    output illm_res_t        res,
    output logic             ram_we,
    output logic [IDX_W-1:0] ram_waddr,
    output logic [WW-1:0]    ram_wdata,
    output logic [IDX_W-1:0] ram_raddr,
    input  logic [WW-1:0]    ram_rdata
);

    localparam int CW = IDX_W + 1;
    localparam int XW = (CW > 8) ? CW : 8;
    localparam int PW = (PAYLOAD_BITS > 16) ? PAYLOAD_BITS : 16;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DEC   = 4'd1;
    localparam logic [3:0] ST_RDOUT = 4'd2;
    localparam logic [3:0] ST_AFTRD = 4'd3;
    localparam logic [3:0] ST_WNEW  = 4'd4;
    localparam logic [3:0] ST_MOD   = 4'd5;
    localparam logic [3:0] ST_DMARK = 4'd6;
    localparam logic [3:0] ST_WSTEP = 4'd7;
    localparam logic [3:0] ST_WDATA = 4'd8;
    localparam logic [3:0] ST_REL1  = 4'd9;
    localparam logic [3:0] ST_REL2  = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } link_t;

    typedef struct packed {
        logic                    del;
        link_t                   prev;
        link_t                   next;
        logic [PAYLOAD_BITS-1:0] pay;
    } entry_t;

    function automatic logic [7:0] to8(input logic [IDX_W-1:0] v);
        logic [XW-1:0] t;
        t = XW'(v);
        return t[7:0];
    endfunction

    function automatic link_t mk(input logic [IDX_W-1:0] v);
        link_t l;
        l.ok  = 1'b1;
        l.idx = v;
        return l;
    endfunction

    logic [3:0]              state_reg, state_next;
    logic [3:0]              ret_reg, ret_next;
    logic [1:0]              func_reg, func_next;
    logic                    at_head_reg, at_head_next;
    logic [XW-1:0]           pos_reg, pos_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [CW-1:0]           count_reg, count_next;
    link_t                   head_reg, head_next;
    link_t                   tail_reg, tail_next;
    logic [IDX_W-1:0]        addr_reg, addr_next;
    logic [1:0]              kind_reg, kind_next;
    link_t                   new_prev_reg, new_prev_next;
    link_t                   new_next_reg, new_next_next;
    logic                    mod_kind_reg, mod_kind_next;
    link_t                   mod_link_reg, mod_link_next;
    link_t                   cur_reg, cur_next;
    logic [CW-1:0]           n_reg, n_next;
    logic                    dir_reg, dir_next;
    link_t                   nn_reg, nn_next;
    link_t                   np_reg, np_next;
    link_t                   pprev_reg, pprev_next;
    logic [1:0]              status_reg, status_next;
    entry_t                  res_entry_reg, res_entry_next;
    logic [IDX_W-1:0]        res_id_reg, res_id_next;

    entry_t                  rd_entry;
    entry_t                  wr_entry;
    logic [PW-1:0]           pay_w;
    logic                    pos_bad;
    logic                    full;
    logic [IDX_W-1:0]        new_id;
    link_t                   null_link;
    logic                    found;
    link_t                   found_link;

    assign rd_entry  = entry_t'(ram_rdata);
    assign ram_wdata = wr_entry;
    assign ram_raddr = addr_next;
    assign pay_w     = PW'(req.payload);
    assign pos_bad   = pos_reg >= XW'(count_reg);
    assign full      = count_reg == CW'(ENTRIES);
    assign new_id    = count_reg[IDX_W-1:0];
    assign null_link = '0;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        func_next      = func_reg;
        at_head_next   = at_head_reg;
        pos_next       = pos_reg;
        pay_next       = pay_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        addr_next      = addr_reg;
        kind_next      = kind_reg;
        new_prev_next  = new_prev_reg;
        new_next_next  = new_next_reg;
        mod_kind_next  = mod_kind_reg;
        mod_link_next  = mod_link_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        dir_next       = dir_reg;
        nn_next        = nn_reg;
        np_next        = np_reg;
        pprev_next     = pprev_reg;
        status_next    = status_reg;
        res_entry_next = res_entry_reg;
        res_id_next    = res_id_reg;
        req_ready      = 1'b0;
        res_valid      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        wr_entry       = '0;
        found          = 1'b0;
        found_link     = null_link;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    func_next    = req.func;
                    at_head_next = req.at_head;
                    pos_next     = XW'(req.position);
                    pay_next     = pay_w[PAYLOAD_BITS-1:0];
                    state_next   = ST_DEC;
                end
            end
            ST_DEC:
            begin
                status_next    = STAT_OK;
                res_entry_next = '0;
                res_id_next    = '0;
                state_next     = ST_DONE;
                case (func_reg)
                    FUNC_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            kind_next     = OPK_APPEND;
                            new_prev_next = tail_reg;
                            new_next_next = null_link;
                            state_next    = ST_WNEW;
                        end
                    end
                    FUNC_INSERT:
                    begin
                        if (!at_head_reg && pos_bad)
                        begin
                            status_next = STAT_NOENTRY;
                        end
                        else if (full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else if (at_head_reg ? !tail_reg.ok
                                 : (tail_reg.ok && (XW'(tail_reg.idx) == pos_reg)))
                        begin
                            kind_next     = OPK_APPEND;
                            new_prev_next = tail_reg;
                            new_next_next = null_link;
                            state_next    = ST_WNEW;
                        end
                        else if (at_head_reg)
                        begin
                            kind_next     = OPK_HEAD;
                            new_prev_next = null_link;
                            new_next_next = head_reg;
                            state_next    = ST_WNEW;
                        end
                        else
                        begin
                            kind_next  = OPK_AFTER;
                            addr_next  = pos_reg[IDX_W-1:0];
                            state_next = ST_AFTRD;
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (pos_bad)
                        begin
                            status_next = STAT_NOENTRY;
                        end
                        else
                        begin
                            addr_next  = pos_reg[IDX_W-1:0];
                            state_next = ST_DMARK;
                        end
                    end
                    default:
                    begin
                        if (pos_bad)
                        begin
                            status_next = STAT_NOENTRY;
                        end
                        else
                        begin
                            addr_next  = pos_reg[IDX_W-1:0];
                            state_next = ST_RDOUT;
                        end
                    end
                endcase
            end
            ST_RDOUT:
            begin
                res_entry_next = rd_entry;
                res_id_next    = addr_reg;
                state_next     = ST_DONE;
            end
            ST_AFTRD:
            begin
                wr_entry      = rd_entry;
                wr_entry.next = mk(new_id);
                ram_we        = 1'b1;
                new_prev_next = mk(addr_reg);
                new_next_next = rd_entry.next;
                state_next    = ST_WNEW;
            end
            ST_WNEW:
            begin
                wr_entry.del   = 1'b0;
                wr_entry.prev  = new_prev_reg;
                wr_entry.next  = new_next_reg;
                wr_entry.pay   = pay_reg;
                ram_we         = 1'b1;
                ram_waddr      = new_id;
                res_entry_next = wr_entry;
                res_id_next    = new_id;
                count_next     = count_reg + CW'(1);
                state_next     = ST_DONE;
                ret_next       = ST_DONE;
                mod_link_next  = mk(new_id);
                case (kind_reg)
                    OPK_APPEND:
                    begin
                        if (tail_reg.ok)
                        begin
                            addr_next     = tail_reg.idx;
                            mod_kind_next = MOD_NEXT;
                            state_next    = ST_MOD;
                        end
                        else
                        begin
                            head_next = mk(new_id);
                        end
                        tail_next = mk(new_id);
                    end
                    OPK_HEAD:
                    begin
                        if (head_reg.ok)
                        begin
                            addr_next     = head_reg.idx;
                            mod_kind_next = MOD_PREV;
                            state_next    = ST_MOD;
                        end
                        else
                        begin
                            tail_next = mk(new_id);
                        end
                        head_next = mk(new_id);
                    end
                    default:
                    begin
                        if (new_next_reg.ok && (CW'(new_next_reg.idx) < count_reg))
                        begin
                            addr_next     = new_next_reg.idx;
                            mod_kind_next = MOD_PREV;
                            state_next    = ST_MOD;
                        end
                    end
                endcase
            end
            ST_MOD:
            begin
                wr_entry = rd_entry;
                case (mod_kind_reg)
                    MOD_NEXT: wr_entry.next = mod_link_reg;
                    default:  wr_entry.prev = mod_link_reg;
                endcase
                ram_we     = 1'b1;
                state_next = ret_reg;
            end
            ST_DMARK:
            begin
                wr_entry       = rd_entry;
                wr_entry.del   = 1'b1;
                ram_we         = 1'b1;
                res_entry_next = wr_entry;
                res_id_next    = addr_reg;
                pprev_next     = rd_entry.prev;
                cur_next       = rd_entry.next;
                n_next         = CW'(1);
                dir_next       = 1'b1;
                state_next     = ST_WSTEP;
            end
            ST_WSTEP:
            begin
                if ((n_reg >= CW'(ENTRIES)) || !cur_reg.ok
                    || (CW'(cur_reg.idx) >= count_reg))
                begin
                    found = 1'b1;
                end
                else
                begin
                    addr_next  = cur_reg.idx;
                    state_next = ST_WDATA;
                end
            end
            ST_WDATA:
            begin
                if (!rd_entry.del)
                begin
                    found      = 1'b1;
                    found_link = cur_reg;
                end
                else
                begin
                    cur_next   = dir_reg ? rd_entry.next : rd_entry.prev;
                    n_next     = n_reg + CW'(1);
                    state_next = ST_WSTEP;
                end
            end
            ST_REL1:
            begin
                if (!nn_reg.ok)
                begin
                    tail_next  = np_reg;
                    state_next = ST_REL2;
                end
                else
                begin
                    addr_next     = nn_reg.idx;
                    mod_kind_next = MOD_PREV;
                    mod_link_next = np_reg;
                    ret_next      = ST_REL2;
                    state_next    = ST_MOD;
                end
            end
            ST_REL2:
            begin
                if (!np_reg.ok)
                begin
                    head_next  = nn_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    addr_next     = np_reg.idx;
                    mod_kind_next = MOD_NEXT;
                    mod_link_next = nn_reg;
                    ret_next      = ST_DONE;
                    state_next    = ST_MOD;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (found)
        begin
            if (dir_reg)
            begin
                nn_next    = found_link;
                dir_next   = 1'b0;
                cur_next   = pprev_reg;
                n_next     = CW'(1);
                state_next = ST_WSTEP;
            end
            else
            begin
                np_next    = found_link;
                state_next = ST_REL1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg       <= ret_next;
        func_reg      <= func_next;
        at_head_reg   <= at_head_next;
        pos_reg       <= pos_next;
        pay_reg       <= pay_next;
        addr_reg      <= addr_next;
        kind_reg      <= kind_next;
        new_prev_reg  <= new_prev_next;
        new_next_reg  <= new_next_next;
        mod_kind_reg  <= mod_kind_next;
        mod_link_reg  <= mod_link_next;
        cur_reg       <= cur_next;
        n_reg         <= n_next;
        dir_reg       <= dir_next;
        nn_reg        <= nn_next;
        np_reg        <= np_next;
        pprev_reg     <= pprev_next;
        status_reg    <= status_next;
        res_entry_reg <= res_entry_next;
        res_id_reg    <= res_id_next;
    end

    always_comb
    begin
        res.status           = status_reg;
        res.entry_id         = to8(res_id_reg);
        res.entry_prev_valid = res_entry_reg.prev.ok;
        res.entry_prev       = res_entry_reg.prev.ok ? to8(res_entry_reg.prev.idx) : 8'd0;
        res.entry_next_valid = res_entry_reg.next.ok;
        res.entry_next       = res_entry_reg.next.ok ? to8(res_entry_reg.next.idx) : 8'd0;
        res.entry_payload    = 16'(PW'(res_entry_reg.pay));
        res.entry_deleted    = res_entry_reg.del;
        res.head_valid       = head_reg.ok;
        res.head             = head_reg.ok ? to8(head_reg.idx) : 8'd0;
        res.tail_valid       = tail_reg.ok;
        res.tail             = tail_reg.ok ? to8(tail_reg.idx) : 8'd0;
    end

    `ILLM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(ENTRIES), "entry count above capacity")
    `ILLM_ASSERT_NEXT(a_count_hold, state_reg != ST_WNEW, $stable(count_reg), "count moved outside entry creation")
    `ILLM_ASSERT_NOW(a_no_write_idle, (state_reg == ST_IDLE) || (state_reg == ST_DONE), !ram_we, "table written while idle")
    `ILLM_ASSERT_NOW(a_full_no_create, state_reg == ST_WNEW, count_reg < CW'(ENTRIES), "entry created in a full table")

endmodule

FILE: sv/indexed_linked_list_manager_top.sv
// Top level of the linked list manager: sequencer, entry table and result register.
// Depends on illm_pkg, illm_ram and illm_seq.
//
//   Channel   Direction  Content
//   s_axis    in         request: tuser = func, tdata = at_head, position, payload
//   m_axis    out        result: tuser = status, tdata = entry, head and tail fields
//
// A request is accepted only when the previous one has handed its result on. A delete
// also walks the deleted entries in both directions to find the nearest live neighbours.
// Each step is paced by the single read and single write port of the entry table.
// Reset clears the count, head and tail; the table needs no clearing.
// A held result stalls the sequencer only once the next result is ready.
module indexed_linked_list_manager_top
    import illm_pkg::*;
#(
    parameter int ENTRIES      = 256,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // at_head, position[7:0], payload[15:0]
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // entry_id, entry_prev_valid, entry_prev,
                                       // entry_next_valid, entry_next, entry_payload,
                                       // entry_deleted, head_valid, head, tail_valid, tail
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int WW    = 3 + 2 * IDX_W + PAYLOAD_BITS;

    illm_req_t        req;
    illm_res_t        res;
    logic             res_valid;
    logic             res_ready;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [WW-1:0]    ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [WW-1:0]    ram_rdata;
    logic             out_valid_reg, out_valid_next;
    illm_res_t        out_data_reg, out_data_next;

    assign req.func     = s_axis_tuser;
    assign req.at_head  = s_axis_tdata[0];
    assign req.position = s_axis_tdata[8:1];
    assign req.payload  = s_axis_tdata[24:9];

    illm_seq #(
        .ENTRIES      (ENTRIES),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .IDX_W        (IDX_W),
        .WW           (WW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    illm_ram #(
        .DEPTH (ENTRIES),
        .AW    (IDX_W),
        .DW    (WW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.status;
    assign m_axis_tdata  = {3'd0,
                            out_data_reg.tail,
                            out_data_reg.tail_valid,
                            out_data_reg.head,
                            out_data_reg.head_valid,
                            out_data_reg.entry_deleted,
                            out_data_reg.entry_payload,
                            out_data_reg.entry_next,
                            out_data_reg.entry_next_valid,
                            out_data_reg.entry_prev,
                            out_data_reg.entry_prev_valid,
                            out_data_reg.entry_id};

endmodule

FILE: tb/illm_checker.sv
`timescale 1ns / 1ps
// Checker for the linked list manager: watches both stream channels, predicts each result.
// Depends on illm_pkg; instantiated by tb_top beside the block.
module illm_checker
    import illm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    output int          errors,
    output int          pending
);

    localparam int SLOTS = 256;

    logic       prv_ok  [SLOTS];
    logic [7:0] prv_idx [SLOTS];
    logic       nxt_ok  [SLOTS];
    logic [7:0] nxt_idx [SLOTS];
    logic [15:0] pay    [SLOTS];
    logic       del     [SLOTS];
    int         count;
    logic       head_ok, tail_ok;
    logic [7:0] head_idx, tail_idx;

    illm_res_t expected_results[$];

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // Nearest live entry from a start entry, following next or prev links.
    function automatic void find_live(input logic [7:0] start, input logic fwd,
                                      output logic ok, output logic [7:0] idx);
        logic       cur_ok;
        logic [7:0] cur;
        cur_ok = 1'b1;
        cur = start;
        ok = 1'b0;
        idx = 8'd0;
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!cur_ok || cur >= count)
                return;
            if (!del[cur])
            begin
                ok = 1'b1;
                idx = cur;
                return;
            end
            if (fwd)
            begin
                cur_ok = nxt_ok[cur];
                cur = nxt_idx[cur];
            end
            else
            begin
                cur_ok = prv_ok[cur];
                cur = prv_idx[cur];
            end
        end
    endfunction

    function automatic void new_entry(input logic [7:0] id, input logic [15:0] p,
                                      input logic pok, input logic [7:0] pidx,
                                      input logic nok, input logic [7:0] nidx);
        pay[id] = p;
        del[id] = 1'b0;
        prv_ok[id] = pok;
        prv_idx[id] = pidx;
        nxt_ok[id] = nok;
        nxt_idx[id] = nidx;
    endfunction

    function automatic logic [7:0] append_entry(input logic [15:0] p);
        logic [7:0] id;
        id = count[7:0];
        new_entry(id, p, tail_ok, tail_idx, 1'b0, 8'd0);
        if (!tail_ok)
        begin
            prv_idx[id] = 8'd0;
            head_ok = 1'b1;
            head_idx = id;
        end
        else
        begin
            nxt_ok[tail_idx] = 1'b1;
            nxt_idx[tail_idx] = id;
        end
        tail_ok = 1'b1;
        tail_idx = id;
        count++;
        return id;
    endfunction

    function automatic illm_res_t apply_request(input illm_req_t r);
        illm_res_t  res;
        logic [1:0] st;
        logic [7:0] id;
        logic       nn_ok, np_ok, nx_ok;
        logic [7:0] nn, np, nx;
        st = STAT_OK;
        id = 8'd0;
        res = '0;
        case (r.func)
            FUNC_APPEND:
            begin
                if (count >= SLOTS)
                    st = STAT_FULL;
                else
                    id = append_entry(r.payload);
            end
            FUNC_INSERT:
            begin
                if (!r.at_head && r.position >= count)
                    st = STAT_NOENTRY;
                else if (count >= SLOTS)
                    st = STAT_FULL;
                else if (r.at_head ? !tail_ok : (tail_ok && tail_idx == r.position))
                    id = append_entry(r.payload);
                else if (r.at_head)
                begin
                    id = count[7:0];
                    new_entry(id, r.payload, 1'b0, 8'd0, head_ok, head_idx);
                    if (head_ok)
                    begin
                        prv_ok[head_idx] = 1'b1;
                        prv_idx[head_idx] = id;
                    end
                    else
                    begin
                        tail_ok = 1'b1;
                        tail_idx = id;
                    end
                    head_ok = 1'b1;
                    head_idx = id;
                    count++;
                end
                else
                begin
                    nx_ok = nxt_ok[r.position];
                    nx = nxt_idx[r.position];
                    id = count[7:0];
                    new_entry(id, r.payload, 1'b1, r.position, nx_ok, nx);
                    nxt_ok[r.position] = 1'b1;
                    nxt_idx[r.position] = id;
                    if (nx_ok && nx < count)
                    begin
                        prv_ok[nx] = 1'b1;
                        prv_idx[nx] = id;
                    end
                    count++;
                end
            end
            FUNC_DELETE:
            begin
                if (r.position >= count)
                    st = STAT_NOENTRY;
                else
                begin
                    id = r.position;
                    del[id] = 1'b1;
                    find_live(id, 1'b1, nn_ok, nn);
                    find_live(id, 1'b0, np_ok, np);
                    if (!nn_ok)
                    begin
                        tail_ok = np_ok;
                        tail_idx = np;
                    end
                    else
                    begin
                        prv_ok[nn] = np_ok;
                        prv_idx[nn] = np;
                    end
                    if (!np_ok)
                    begin
                        head_ok = nn_ok;
                        head_idx = nn;
                    end
                    else
                    begin
                        nxt_ok[np] = nn_ok;
                        nxt_idx[np] = nn;
                    end
                end
            end
            default:
            begin
                if (r.position >= count)
                    st = STAT_NOENTRY;
                else
                    id = r.position;
            end
        endcase
        res.status = st;
        if (st == STAT_OK)
        begin
            res.entry_id = id;
            res.entry_prev_valid = prv_ok[id];
            res.entry_prev = prv_ok[id] ? prv_idx[id] : 8'd0;
            res.entry_next_valid = nxt_ok[id];
            res.entry_next = nxt_ok[id] ? nxt_idx[id] : 8'd0;
            res.entry_payload = pay[id];
            res.entry_deleted = del[id];
        end
        res.head_valid = head_ok;
        res.head = head_ok ? head_idx : 8'd0;
        res.tail_valid = tail_ok;
        res.tail = tail_ok ? tail_idx : 8'd0;
        return res;
    endfunction

    function automatic illm_res_t unpack_result(input logic [63:0] d, input logic [1:0] u);
        illm_res_t r;
        r.status = u;
        r.entry_id = d[7:0];
        r.entry_prev_valid = d[8];
        r.entry_prev = d[16:9];
        r.entry_next_valid = d[17];
        r.entry_next = d[25:18];
        r.entry_payload = d[41:26];
        r.entry_deleted = d[42];
        r.head_valid = d[43];
        r.head = d[51:44];
        r.tail_valid = d[52];
        r.tail = d[60:53];
        return r;
    endfunction

    initial
    begin
        errors = 0;
        count = 0;
        head_ok = 1'b0;
        tail_ok = 1'b0;
        head_idx = 8'd0;
        tail_idx = 8'd0;
    end

    assign pending = expected_results.size();

    always @(posedge clk)
    begin
        illm_req_t req;
        illm_res_t got, want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            req.func = s_axis_tuser;
            req.at_head = s_axis_tdata[0];
            req.position = s_axis_tdata[8:1];
            req.payload = s_axis_tdata[24:9];
            expected_results.push_back(apply_request(req));
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = unpack_result(m_axis_tdata, m_axis_tuser);
            if (expected_results.size() == 0)
            begin
                report("unexpected result", m_axis_tdata, 64'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status != want.status)
                    report("status", got.status, want.status);
                if (got.entry_id != want.entry_id)
                    report("entry_id", got.entry_id, want.entry_id);
                if (got.entry_prev_valid != want.entry_prev_valid)
                    report("entry_prev_valid", got.entry_prev_valid, want.entry_prev_valid);
                if (got.entry_prev != want.entry_prev)
                    report("entry_prev", got.entry_prev, want.entry_prev);
                if (got.entry_next_valid != want.entry_next_valid)
                    report("entry_next_valid", got.entry_next_valid, want.entry_next_valid);
                if (got.entry_next != want.entry_next)
                    report("entry_next", got.entry_next, want.entry_next);
                if (got.entry_payload != want.entry_payload)
                    report("entry_payload", got.entry_payload, want.entry_payload);
                if (got.entry_deleted != want.entry_deleted)
                    report("entry_deleted", got.entry_deleted, want.entry_deleted);
                if (got.head_valid != want.head_valid)
                    report("head_valid", got.head_valid, want.head_valid);
                if (got.head != want.head)
                    report("head", got.head, want.head);
                if (got.tail_valid != want.tail_valid)
                    report("tail_valid", got.tail_valid, want.tail_valid);
                if (got.tail != want.tail)
                    report("tail", got.tail, want.tail);
            end
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the linked list manager testbench: clock, reset, request and result traffic.
// Depends on illm_pkg, indexed_linked_list_manager_top and illm_checker.
module tb_top;
    import illm_pkg::*;

    localparam int NUM_RANDOM = 1500;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 600;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    int          errors;
    int          pending;
    int          sent;
    int          received;
    int          created;
    int          idle_cycles;
    logic        burst;

    indexed_linked_list_manager_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    illm_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int draw_gap();
        if ($urandom_range(0, 29) == 0)
            burst = ~burst;
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic send_request(input logic [1:0] func, input logic at_head,
                                input logic [7:0] position, input logic [15:0] payload);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {7'd0, payload, position, at_head};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent++;
        if (created < 256 && (func == FUNC_APPEND ||
            (func == FUNC_INSERT && (at_head || position < created))))
            created++;
    endtask

    task automatic send_random();
        logic [1:0] func;
        logic [7:0] position;
        func = 2'($urandom_range(0, 3));
        if (created > 0 && $urandom_range(0, 99) < 85)
            position = 8'($urandom_range(0, created - 1));
        else
            position = 8'($urandom_range(0, 255));
        send_request(func, 1'($urandom_range(0, 3) == 0), position, 16'($urandom));
    endtask

    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (received == 200)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = draw_gap();
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            received++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_APPEND;
        sent = 0;
        received = 0;
        created = 0;
        idle_cycles = 0;
        burst = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Errors on an empty table, then build and reshape a short list.
        send_request(FUNC_READ, 1'b0, 8'd0, 16'h1234);
        send_request(FUNC_DELETE, 1'b0, 8'd0, 16'h0000);
        send_request(FUNC_INSERT, 1'b0, 8'd0, 16'h0001);
        send_request(FUNC_INSERT, 1'b1, 8'd255, 16'h0000);
        send_request(FUNC_APPEND, 1'b0, 8'd0, 16'hFFFF);
        send_request(FUNC_INSERT, 1'b0, 8'd1, 16'hA5A5);
        send_request(FUNC_INSERT, 1'b1, 8'd0, 16'h5A5A);
        send_request(FUNC_INSERT, 1'b0, 8'd0, 16'h8000);
        send_request(FUNC_APPEND, 1'b1, 8'd255, 16'h7FFF);
        send_request(FUNC_DELETE, 1'b0, 8'd4, 16'h0000);
        send_request(FUNC_DELETE, 1'b0, 8'd3, 16'h0000);
        send_request(FUNC_DELETE, 1'b0, 8'd2, 16'h0000);
        send_request(FUNC_DELETE, 1'b0, 8'd2, 16'h0000);
        send_request(FUNC_INSERT, 1'b0, 8'd3, 16'h0F0F);
        send_request(FUNC_DELETE, 1'b0, 8'd5, 16'h0000);
        send_request(FUNC_INSERT, 1'b0, 8'd5, 16'hF0F0);
        send_request(FUNC_READ, 1'b0, 8'd3, 16'h0000);
        send_request(FUNC_READ, 1'b0, 8'd255, 16'hFFFF);
        send_request(FUNC_DELETE, 1'b0, 8'd255, 16'h0000);
        send_request(FUNC_INSERT, 1'b0, 8'd200, 16'h0000);
        send_request(FUNC_READ, 1'b1, 8'd0, 16'hFFFF);

        for (int i = 0; i < NUM_RANDOM; i++)
            send_random();
        s_axis_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (1100) @(posedge clk);

        $display("Sent %0d requests and took %0d results; %0d entries were created.",
                 sent, received, created);
        $display("The run included full-table errors, unknown entries and a long output stall.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
